// File: design/ilst_pkg.sv
// Shared types and constants for the indexed list store.
`default_nettype none

package ilst_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned LEN_W  = 5;

  localparam logic signed [DATA_W-1:0] READ_INVALID = -32'sd1;

  typedef enum logic [2:0] {
    CMD_GET      = 3'd0,
    CMD_ADD_HEAD = 3'd1,
    CMD_ADD_TAIL = 3'd2,
    CMD_ADD_POS  = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [LEN_W-1:0]         length;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/ilst_cell.sv
// One storage cell of the list chain: hold, take a neighbor's value, or load.
`default_nettype none

module ilst_cell #(
  parameter int unsigned CMP_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  wire logic                              clk,
  input  wire ilst_pkg::cell_ctl_t               ctl,
  input  wire logic [CMP_W-1:0]                  shift_pos,
  input  wire logic signed [ilst_pkg::DATA_W-1:0] new_value,
  input  wire logic signed [ilst_pkg::DATA_W-1:0] left_q,
  input  wire logic signed [ilst_pkg::DATA_W-1:0] right_q,
  output logic signed [ilst_pkg::DATA_W-1:0]      q
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic signed [ilst_pkg::DATA_W-1:0] data_r;
  logic signed [ilst_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX == shift_pos) begin
        data_nxt = new_value;
      end else if (MY_IDX > shift_pos) begin
        data_nxt = left_q;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= shift_pos) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

// File: design/ilst_ctrl.sv
// Command decode, entry count, range and full checks, and the result register.
`default_nettype none

module ilst_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned CMP_W    = 5
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire ilst_pkg::in_item_t                 in_item,
  output logic                                    in_stall,
  output logic                                    out_valid,
  output ilst_pkg::out_item_t                     out_item,
  input  wire logic                               out_stall,
  input  wire logic signed [ilst_pkg::DATA_W-1:0] rd_data,
  output ilst_pkg::cell_ctl_t                     ctl,
  output logic [CMP_W-1:0]                        shift_pos
);

  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  ilst_pkg::out_item_t  out_item_r;
  logic                 accept;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     ins_pos;
  logic                 is_add;
  logic                 want_ins;
  logic                 want_del;
  logic signed [ilst_pkg::DATA_W-1:0] rd_val;
  ilst_pkg::status_t    st;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cnt_ext  = CMP_W'(cnt_r);
  assign pos_ext  = CMP_W'(in_item.position);

  // Decode: which insert position, and whether an add or delete is legal
  always_comb begin
    ins_pos  = pos_ext;
    is_add   = 1'b0;
    want_ins = 1'b0;
    want_del = 1'b0;
    rd_val   = '0;
    st       = ilst_pkg::ST_DONE;
    case (ilst_pkg::cmd_t'(in_item.cmd))
      ilst_pkg::CMD_GET: begin
        if (pos_ext < cnt_ext) begin
          rd_val = rd_data;
        end else begin
          rd_val = ilst_pkg::READ_INVALID;
          st     = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::CMD_ADD_HEAD: begin
        ins_pos = '0;
        is_add  = 1'b1;
      end
      ilst_pkg::CMD_ADD_TAIL: begin
        ins_pos = cnt_ext;
        is_add  = 1'b1;
      end
      ilst_pkg::CMD_ADD_POS: begin
        is_add = 1'b1;
      end
      ilst_pkg::CMD_DELETE: begin
        if (pos_ext < cnt_ext) begin
          want_del = 1'b1;
        end else begin
          st = ilst_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    // position check wins over the full check
    if (is_add) begin
      if (ins_pos > cnt_ext) begin
        st = ilst_pkg::ST_RANGE;
      end else if (cnt_ext == CAP_C) begin
        st = ilst_pkg::ST_FULL;
      end else begin
        want_ins = 1'b1;
      end
    end
  end

  always_comb begin
    ctl.ins   = accept & want_ins;
    ctl.del   = accept & want_del;
    shift_pos = want_ins ? ins_pos : pos_ext;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.read_value <= rd_val;
      out_item_r.status     <= st;
      out_item_r.length     <= ilst_pkg::LEN_W'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: design/indexed_list_store.sv
// Indexed list store top level: control plus a chain of storage cells.
//
// Ordered list of up to CAPACITY signed 32-bit values, one command per item
// (get, add at head, add at tail, add at position, delete at position). Every
// item gives exactly one result with the read value, a status and the new
// length (low 5 bits). Throughput is one item per clock while not stalled:
// every cell of the chain picks hold, left neighbor, right neighbor or new value
// in the same cycle, so inserts and deletes shift the whole list at once. The
// result appears in the output register the cycle after the item is accepted;
// the input stalls only while that register holds a result the downstream side
// is stalling. Positions are 5 bits, so get, add at position and delete reach
// the first 32 entries; add at tail reaches any free entry. Reset clears the
// entry count and the output valid flag; no clearing pass is needed.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire ilst_pkg::in_item_t  in_item,
  output logic                     in_stall,
  output logic                     out_valid,
  output ilst_pkg::out_item_t      out_item,
  input  wire logic                out_stall
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > ilst_pkg::POS_W) ? CNT_W : ilst_pkg::POS_W;
  localparam int unsigned RD_N  = 1 << ilst_pkg::POS_W;

  ilst_pkg::cell_ctl_t                ctl;
  logic [CMP_W-1:0]                   shift_pos;
  logic signed [ilst_pkg::DATA_W-1:0] cell_q [CAPACITY];
  logic signed [ilst_pkg::DATA_W-1:0] rd_tab [RD_N];
  logic signed [ilst_pkg::DATA_W-1:0] rd_data;

  ilst_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .CMP_W    (CMP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .rd_data   (rd_data),
    .ctl       (ctl),
    .shift_pos (shift_pos)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ilst_pkg::DATA_W-1:0] left_q;
    logic signed [ilst_pkg::DATA_W-1:0] right_q;

    // cell 0 never takes a left value; the last cell's right value is don't-care
    if (i == 0) begin : g_first
      assign left_q = in_item.item_value;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    ilst_cell #(
      .CMP_W (CMP_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_pos (shift_pos),
      .new_value (in_item.item_value),
      .left_q    (left_q),
      .right_q   (right_q),
      .q         (cell_q[i])
    );
  end

  // Read port covers the positions the 5-bit field can address
  for (genvar j = 0; j < RD_N; j++) begin : g_rd
    if (j < CAPACITY) begin : g_have
      assign rd_tab[j] = cell_q[j];
    end else begin : g_none
      assign rd_tab[j] = '0;
    end
  end

  assign rd_data = rd_tab[in_item.position];

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item did not produce a result");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ilst_pkg::ST_FULL)
      |-> (out_item.length == ilst_pkg::LEN_W'(CAPACITY)))
    else $error("full status with length below capacity");

  a_full_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ilst_pkg::ST_FULL) |-> (out_item.read_value == '0))
    else $error("full status carries a read value");
`endif

endmodule

`default_nettype wire

// File: tb/sv/ilst_checker.sv
// Result checker for the indexed list store: tracks the list and compares every result.
`timescale 1ns / 100ps

module ilst_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ilst_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ilst_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  results_seen,
  output int                  range_hits,
  output int                  full_hits
);

  logic signed [ilst_pkg::DATA_W-1:0] list_values [DEPTH];
  int unsigned                        list_len;
  ilst_pkg::out_item_t                expected_results [$];
  ilst_pkg::out_item_t                oldest;
  ilst_pkg::out_item_t                fresh;
  int                                 fails;
  int                                 seen;
  int                                 ranges;
  int                                 fulls;

  initial begin
    list_len = 0;
    fails    = 0;
    seen     = 0;
    ranges   = 0;
    fulls    = 0;
  end

  function automatic ilst_pkg::status_t insert_value(int unsigned pos,
                                                     logic signed [31:0] value);
    if (pos > list_len) return ilst_pkg::ST_RANGE;
    if (list_len >= DEPTH) return ilst_pkg::ST_FULL;
    for (int unsigned i = list_len; i > pos; i--) list_values[i] = list_values[i-1];
    list_values[pos] = value;
    list_len++;
    return ilst_pkg::ST_DONE;
  endfunction

  // Applies one command to the tracked list and returns the result it should give.
  function automatic ilst_pkg::out_item_t apply_command(ilst_pkg::in_item_t it);
    ilst_pkg::out_item_t res;
    ilst_pkg::status_t   st;
    int unsigned         pos;
    pos            = it.position;
    st             = ilst_pkg::ST_DONE;
    res.read_value = '0;
    case (it.cmd)
      ilst_pkg::CMD_GET: begin
        if (pos < list_len) begin
          res.read_value = list_values[pos];
        end else begin
          res.read_value = ilst_pkg::READ_INVALID;
          st             = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::CMD_ADD_HEAD: st = insert_value(0, it.item_value);
      ilst_pkg::CMD_ADD_TAIL: st = insert_value(list_len, it.item_value);
      ilst_pkg::CMD_ADD_POS:  st = insert_value(pos, it.item_value);
      ilst_pkg::CMD_DELETE: begin
        if (pos < list_len) begin
          for (int unsigned i = pos; i + 1 < list_len; i++) list_values[i] = list_values[i+1];
          list_len--;
        end else begin
          st = ilst_pkg::ST_RANGE;
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
    res.status = st;
    res.length = list_len[ilst_pkg::LEN_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // a result leaving now belongs to an earlier item, so check before pushing
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: read_value %0d status %0d length %0d",
                 out_item.read_value, out_item.status, out_item.length);
          fails++;
        end else begin
          oldest = expected_results.pop_front();
          seen++;
          if (out_item.read_value !== oldest.read_value) begin
            $error("read_value mismatch: expected %0d, got %0d",
                   oldest.read_value, out_item.read_value);
            fails++;
          end
          if (out_item.status !== oldest.status) begin
            $error("status mismatch: expected %0d, got %0d", oldest.status, out_item.status);
            fails++;
          end
          if (out_item.length !== oldest.length) begin
            $error("length mismatch: expected %0d, got %0d", oldest.length, out_item.length);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh = apply_command(in_item);
        if (fresh.status == ilst_pkg::ST_RANGE) ranges++;
        if (fresh.status == ilst_pkg::ST_FULL) fulls++;
        expected_results.push_back(fresh);
      end
    end
    fail_count    <= fails;
    pending_count <= expected_results.size();
    results_seen  <= seen;
    range_hits    <= ranges;
    full_hits     <= fulls;
  end

endmodule

// File: tb/sv/tb_indexed_list_store.sv
// Testbench top for the indexed list store: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_indexed_list_store;

  localparam int unsigned LIST_DEPTH      = 16;
  localparam int          RANDOM_ITEMS    = 1500;
  localparam int          CYCLE_LIMIT     = 600000;
  localparam int          HOLD_OFF_AFTER  = 400;
  localparam int          HOLD_OFF_CYCLES = 150;
  localparam int          DRAIN_CYCLES    = 4;
  localparam logic [2:0]  CMD_UNUSED_LO   = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI   = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  ilst_pkg::in_item_t  in_item;
  logic                in_stall;
  logic                out_valid;
  ilst_pkg::out_item_t out_item;
  logic                out_stall;

  int fail_count;
  int pending_count;
  int results_seen;
  int range_hits;
  int full_hits;

  int cycle_count = 0;
  int burst_left  = 0;
  int get_count   = 0;
  int add_count   = 0;
  int del_count   = 0;
  int unused_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_list_store #(
    .CAPACITY (LIST_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  ilst_checker #(
    .DEPTH (LIST_DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .results_seen  (results_seen),
    .range_hits    (range_hits),
    .full_hits     (full_hits)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, a few long ones, and now and then a gapless burst.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [4:0] pos,
                           input logic signed [31:0] value);
    int gap;
    in_item  <= '{cmd: cmd, position: pos, item_value: value};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    case (cmd)
      ilst_pkg::CMD_GET:      get_count++;
      ilst_pkg::CMD_ADD_HEAD,
      ilst_pkg::CMD_ADD_TAIL,
      ilst_pkg::CMD_ADD_POS:  add_count++;
      ilst_pkg::CMD_DELETE:   del_count++;
      default:                unused_count++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin
    int  run;
    bit  held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 55) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    bit                 add_heavy;
    int                 phase_left;
    int                 r;
    logic [2:0]         cmd;
    logic [4:0]         pos;
    logic signed [31:0] value;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: get, delete and add at position 1 miss; then the list is built up
    send_item(ilst_pkg::CMD_GET, 5'd0, 32'sd0);
    send_item(ilst_pkg::CMD_DELETE, 5'd0, 32'sd0);
    send_item(ilst_pkg::CMD_ADD_POS, 5'd1, 32'sd5);
    send_item(ilst_pkg::CMD_ADD_POS, 5'd0, 32'sh7fffffff);
    send_item(ilst_pkg::CMD_ADD_TAIL, 5'd0, 32'sh80000000);
    send_item(ilst_pkg::CMD_ADD_HEAD, 5'd31, -32'sd1);
    send_item(ilst_pkg::CMD_ADD_POS, 5'd2, 32'sd0);
    // position equal to the length appends; one past it is refused
    send_item(ilst_pkg::CMD_ADD_POS, 5'd4, 32'sh12345678);
    send_item(ilst_pkg::CMD_ADD_POS, 5'd6, 32'sd1);
    for (int i = 0; i <= 5; i++) send_item(ilst_pkg::CMD_GET, 5'(i), 32'sd0);
    send_item(ilst_pkg::CMD_GET, 5'd31, 32'sd0);
    send_item(ilst_pkg::CMD_DELETE, 5'd31, 32'sd0);
    send_item(ilst_pkg::CMD_DELETE, 5'd3, 32'sd0);
    send_item(ilst_pkg::CMD_DELETE, 5'd0, 32'sd0);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_item(3'(c), 5'd31, -32'sd1);

    // alternate fill-heavy and drain-heavy phases so the list swings between empty and full
    add_heavy  = 1'b0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        add_heavy  = !add_heavy;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r >= 96) begin
        cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end else if (add_heavy) begin
        if (r < 15) cmd = ilst_pkg::CMD_GET;
        else if (r < 30) cmd = ilst_pkg::CMD_ADD_HEAD;
        else if (r < 50) cmd = ilst_pkg::CMD_ADD_TAIL;
        else if (r < 80) cmd = ilst_pkg::CMD_ADD_POS;
        else cmd = ilst_pkg::CMD_DELETE;
      end else begin
        if (r < 20) cmd = ilst_pkg::CMD_GET;
        else if (r < 27) cmd = ilst_pkg::CMD_ADD_HEAD;
        else if (r < 34) cmd = ilst_pkg::CMD_ADD_TAIL;
        else if (r < 42) cmd = ilst_pkg::CMD_ADD_POS;
        else cmd = ilst_pkg::CMD_DELETE;
      end
      if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(0, LIST_DEPTH + 1));
      else pos = 5'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        value = 32'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0:       value = 32'sd0;
          1:       value = -32'sd1;
          2:       value = 32'sh7fffffff;
          3:       value = 32'sh80000000;
          default: value = 32'sd1;
        endcase
      end
      send_item(cmd, pos, value);
    end
    in_valid <= 1'b0;

    // the outstanding count is registered, so let the last item land in it first
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d gets, %0d adds, %0d deletes, %0d unused codes.",
             get_count + add_count + del_count + unused_count,
             get_count, add_count, del_count, unused_count);
    $display("Checked %0d results, of which %0d out of range and %0d refused as full.",
             results_seen, range_hits, full_hits);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
